// ===== design/min_sec_countdown_timer_macros.svh =====
// ----------------------------------------------------------------------------
// min_sec_countdown_timer_macros
// Assertion macros shared by the countdown timer RTL.
// ----------------------------------------------------------------------------
`ifndef MIN_SEC_COUNTDOWN_TIMER_MACROS_SVH
`define MIN_SEC_COUNTDOWN_TIMER_MACROS_SVH

// same-cycle implication, sampled on i_clk, off while in reset
`define MSCT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("countdown timer check failed");

// next-cycle implication, sampled on i_clk, off while in reset
`define MSCT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("countdown timer check failed");

`endif

// ===== design/msct_pkg.sv =====
// ----------------------------------------------------------------------------
// msct_pkg
// Types and constants for the minutes:seconds countdown timer.
// ----------------------------------------------------------------------------
`default_nettype none

package msct_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_RUN   = 2'd1,
        MODE_ALARM = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        CMD_TICK       = 3'd0,
        CMD_PRESS      = 3'd1,
        CMD_RELEASE    = 3'd2,
        CMD_START_STOP = 3'd3,
        CMD_CLEAR      = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        BTN_MIN_UP   = 2'd0,
        BTN_MIN_DOWN = 2'd1,
        BTN_SEC_UP   = 2'd2,
        BTN_SEC_DOWN = 2'd3
    } t_btn;

    typedef enum logic [2:0] {
        REG_TICKS_PER_SECOND = 3'd0,
        REG_REPEAT_SLOW      = 3'd1,
        REG_REPEAT_MID       = 3'd2,
        REG_REPEAT_FAST      = 3'd3,
        REG_ALARM_PERIOD     = 3'd4,
        REG_ALARM_PULSES     = 3'd5,
        REG_MAX_MINUTES      = 3'd6
    } t_reg;

    localparam logic [5:0] SEC_MAX    = 6'd59;
    localparam logic [4:0] MID_AFTER  = 5'd6;
    localparam logic [4:0] FAST_AFTER = 5'd18;

    localparam logic [15:0] RST_TICKS_PER_SECOND = 16'd1000;
    localparam logic [15:0] RST_REPEAT_SLOW      = 16'd500;
    localparam logic [15:0] RST_REPEAT_MID       = 16'd250;
    localparam logic [15:0] RST_REPEAT_FAST      = 16'd125;
    localparam logic [15:0] RST_ALARM_PERIOD     = 16'd6000;
    localparam logic [5:0]  RST_ALARM_PULSES     = 6'd20;
    localparam logic [6:0]  RST_MAX_MINUTES      = 7'd99;

endpackage

`default_nettype wire

// ===== design/min_sec_countdown_timer.sv =====
// ----------------------------------------------------------------------------
// min_sec_countdown_timer
// Event-driven minutes:seconds countdown timer with button auto-repeat and
// a pulsed alarm phase.
// ----------------------------------------------------------------------------
// One word is taken per clock cycle while o_ready is high, and every word
// gives exactly one result word. A word is held in the input register, then
// the whole state update (time, mode, tick and repeat counters) is worked out
// in a single pass and lands in the state and result registers together.
// The input side keeps taking words while a result waits, and stops only when
// both registers are full.
// Configuration writes take effect at once and are meant for idle periods.
`default_nettype none

`include "min_sec_countdown_timer_macros.svh"

module min_sec_countdown_timer
    import msct_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,

    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_command,
    input  wire logic [1:0]  i_button,

    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [6:0]       o_minutes,
    output logic [5:0]       o_seconds,
    output logic             o_running,
    output logic             o_alarming,
    output logic             o_alarm_pulse
);

    // configuration
    logic [15:0] r_tps, r_rep_slow, r_rep_mid, r_rep_fast, r_alm_period;
    logic [5:0]  r_alm_pulses;
    logic [6:0]  r_max_min;

    // input register
    logic        r_in_valid;
    t_cmd        r_cmd;
    t_btn        r_btn;

    // state
    t_mode       r_mode, n_mode;
    logic [6:0]  r_min, n_min;
    logic [5:0]  r_sec, n_sec;
    logic [15:0] r_sec_ticks, n_sec_ticks;
    logic        r_held, n_held;
    t_btn        r_held_btn, n_held_btn;
    logic [15:0] r_rep_ticks, n_rep_ticks;
    logic [4:0]  r_rep_num, n_rep_num;
    logic [15:0] r_alm_ticks, n_alm_ticks;
    logic [5:0]  r_alm_num, n_alm_num;

    // result register
    logic        r_out_valid;
    logic [6:0]  r_out_min;
    logic [5:0]  r_out_sec;
    logic        r_out_run, r_out_alm, r_out_pulse;

    // handshake
    logic        advance, process;

    // datapath
    logic        is_idle, is_run, is_alarm;
    logic        cmd_tick, cmd_start, cmd_press;
    logic [15:0] rep_iv;
    logic [16:0] rep_inc, sec_inc, alm_inc;
    logic        rep_fire, sec_fire, alm_fire, alm_done;
    logic        do_btn, do_count;
    t_btn        step_btn;
    logic        cur_zero, dec_zero;
    logic [6:0]  dec_min, btn_min;
    logic [5:0]  dec_sec, btn_sec;
    logic        n_pulse;

    assign advance = !r_out_valid || i_ready;
    assign process = r_in_valid && advance;
    assign o_ready = !r_in_valid || advance;

    // ------------------------------------------------------------------ config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps        <= RST_TICKS_PER_SECOND;
            r_rep_slow   <= RST_REPEAT_SLOW;
            r_rep_mid    <= RST_REPEAT_MID;
            r_rep_fast   <= RST_REPEAT_FAST;
            r_alm_period <= RST_ALARM_PERIOD;
            r_alm_pulses <= RST_ALARM_PULSES;
            r_max_min    <= RST_MAX_MINUTES;
        end else if (i_cfg_we) begin
            unique case (t_reg'(i_cfg_index))
                REG_TICKS_PER_SECOND: r_tps        <= i_cfg_data;
                REG_REPEAT_SLOW:      r_rep_slow   <= i_cfg_data;
                REG_REPEAT_MID:       r_rep_mid    <= i_cfg_data;
                REG_REPEAT_FAST:      r_rep_fast   <= i_cfg_data;
                REG_ALARM_PERIOD:     r_alm_period <= i_cfg_data;
                REG_ALARM_PULSES:     r_alm_pulses <= i_cfg_data[5:0];
                REG_MAX_MINUTES:      r_max_min    <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------- input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cmd <= t_cmd'(i_command);
            r_btn <= t_btn'(i_button);
        end
    end

    // ---------------------------------------------------------------- events
    always_comb begin
        is_idle   = (r_mode == MODE_IDLE);
        is_run    = (r_mode == MODE_RUN);
        is_alarm  = (r_mode == MODE_ALARM);
        cmd_tick  = (r_cmd == CMD_TICK);
        cmd_start = (r_cmd == CMD_START_STOP);
        cmd_press = (r_cmd == CMD_PRESS);

        if (r_rep_num < MID_AFTER) begin
            rep_iv = r_rep_slow;
        end else if (r_rep_num < FAST_AFTER) begin
            rep_iv = r_rep_mid;
        end else begin
            rep_iv = r_rep_fast;
        end

        rep_inc  = {1'b0, r_rep_ticks} + 17'd1;
        sec_inc  = {1'b0, r_sec_ticks} + 17'd1;
        alm_inc  = {1'b0, r_alm_ticks} + 17'd1;
        rep_fire = is_idle && cmd_tick && r_held && (rep_inc >= {1'b0, rep_iv});
        sec_fire = is_run && cmd_tick && (sec_inc >= {1'b0, r_tps});
        alm_fire = is_alarm && cmd_tick && (alm_inc >= {1'b0, r_alm_period});
        alm_done = alm_fire && (r_alm_num >= r_alm_pulses);

        do_btn   = (is_idle && cmd_press) || rep_fire;
        step_btn = cmd_press ? r_btn : r_held_btn;
        do_count = sec_fire || (is_idle && cmd_start);
    end

    // ------------------------------------------------------------------ time
    always_comb begin
        cur_zero = (r_min == 7'd0) && (r_sec == 6'd0);
        if (r_sec == 6'd0) begin
            dec_min = r_min - 7'd1;
            dec_sec = SEC_MAX;
        end else begin
            dec_min = r_min;
            dec_sec = r_sec - 6'd1;
        end
        dec_zero = (dec_min == 7'd0) && (dec_sec == 6'd0);

        btn_min = r_min;
        btn_sec = r_sec;
        case (step_btn)
            BTN_MIN_UP: begin
                if (r_min < r_max_min) btn_min = r_min + 7'd1;
            end
            BTN_MIN_DOWN: begin
                if (r_min != 7'd0) btn_min = r_min - 7'd1;
            end
            BTN_SEC_UP: begin
                if (r_sec < SEC_MAX) begin
                    btn_sec = r_sec + 6'd1;
                end else if (r_min < r_max_min) begin
                    btn_min = r_min + 7'd1;
                    btn_sec = 6'd0;
                end
            end
            default: begin
                if (r_sec != 6'd0) begin
                    btn_sec = r_sec - 6'd1;
                end else if (r_min != 7'd0) begin
                    btn_min = r_min - 7'd1;
                    btn_sec = SEC_MAX;
                end
            end
        endcase

        n_min = r_min;
        n_sec = r_sec;
        if (do_btn) begin
            n_min = btn_min;
            n_sec = btn_sec;
        end else if (do_count && !cur_zero) begin
            n_min = dec_min;
            n_sec = dec_sec;
        end else if (is_idle && (r_cmd == CMD_CLEAR)) begin
            n_min = 7'd0;
            n_sec = 6'd0;
        end
    end

    // ------------------------------------------------------------ next mode
    always_comb begin
        n_mode = r_mode;
        unique case (r_mode)
            MODE_IDLE: begin
                if (cmd_start && !cur_zero) begin
                    n_mode = dec_zero ? MODE_ALARM : MODE_RUN;
                end
            end
            MODE_RUN: begin
                if (cmd_start || (sec_fire && cur_zero)) begin
                    n_mode = MODE_IDLE;
                end else if (sec_fire && dec_zero) begin
                    n_mode = MODE_ALARM;
                end
            end
            MODE_ALARM: begin
                if (cmd_start || alm_done) n_mode = MODE_IDLE;
            end
            default: n_mode = MODE_IDLE;
        endcase
    end

    // ------------------------------------------------------- counters, pulse
    always_comb begin
        n_pulse = (do_count && !cur_zero && dec_zero) || (alm_fire && !alm_done);

        n_sec_ticks = r_sec_ticks;
        if (sec_fire) begin
            n_sec_ticks = 16'd0;
        end else if (is_run && cmd_tick) begin
            n_sec_ticks = sec_inc[15:0];
        end
        if (n_mode != MODE_RUN || (is_idle && cmd_start)) n_sec_ticks = 16'd0;

        n_alm_ticks = r_alm_ticks;
        n_alm_num   = r_alm_num;
        if (do_count && !cur_zero && dec_zero) begin
            n_alm_ticks = 16'd0;
            n_alm_num   = 6'd1;
        end else if (alm_fire) begin
            n_alm_ticks = 16'd0;
            n_alm_num   = r_alm_num + 6'd1;
        end else if (is_alarm && cmd_tick) begin
            n_alm_ticks = alm_inc[15:0];
        end
        if (n_mode != MODE_ALARM) begin
            n_alm_ticks = 16'd0;
            n_alm_num   = 6'd0;
        end

        n_held      = r_held;
        n_held_btn  = r_held_btn;
        n_rep_ticks = r_rep_ticks;
        n_rep_num   = r_rep_num;
        if (is_idle && cmd_press) begin
            n_held      = 1'b1;
            n_held_btn  = r_btn;
            n_rep_ticks = 16'd0;
            n_rep_num   = 5'd0;
        end else if ((r_cmd == CMD_RELEASE) || (is_idle && cmd_start)) begin
            n_held      = 1'b0;
            n_held_btn  = BTN_MIN_UP;
            n_rep_ticks = 16'd0;
            n_rep_num   = 5'd0;
        end else if (rep_fire) begin
            n_rep_ticks = 16'd0;
            if (r_rep_num < FAST_AFTER) n_rep_num = r_rep_num + 5'd1;
        end else if (is_idle && cmd_tick && r_held) begin
            n_rep_ticks = rep_inc[15:0];
        end
    end

    // ---------------------------------------------------------- state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_min       <= 7'd0;
            r_sec       <= 6'd0;
            r_sec_ticks <= 16'd0;
            r_held      <= 1'b0;
            r_held_btn  <= BTN_MIN_UP;
            r_rep_ticks <= 16'd0;
            r_rep_num   <= 5'd0;
            r_alm_ticks <= 16'd0;
            r_alm_num   <= 6'd0;
        end else if (process) begin
            r_mode      <= n_mode;
            r_min       <= n_min;
            r_sec       <= n_sec;
            r_sec_ticks <= n_sec_ticks;
            r_held      <= n_held;
            r_held_btn  <= n_held_btn;
            r_rep_ticks <= n_rep_ticks;
            r_rep_num   <= n_rep_num;
            r_alm_ticks <= n_alm_ticks;
            r_alm_num   <= n_alm_num;
        end
    end

    // --------------------------------------------------------- result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process) begin
            r_out_min   <= n_min;
            r_out_sec   <= n_sec;
            r_out_run   <= (n_mode == MODE_RUN);
            r_out_alm   <= (n_mode == MODE_ALARM);
            r_out_pulse <= n_pulse;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_minutes     = r_out_min;
    assign o_seconds     = r_out_sec;
    assign o_running     = r_out_run;
    assign o_alarming    = r_out_alm;
    assign o_alarm_pulse = r_out_pulse;

    // ------------------------------------------------------------ assertions
    `MSCT_ASSERT_NOW(a_run_nonzero, r_mode == MODE_RUN, (r_min != 7'd0) || (r_sec != 6'd0))
    `MSCT_ASSERT_NOW(a_rep_sat, 1'b1, r_rep_num <= FAST_AFTER)
    `MSCT_ASSERT_NOW(a_pulse_in_alarm, o_valid && o_alarm_pulse, o_alarming && !o_running)
    `MSCT_ASSERT_NOW(a_sec_range, 1'b1, r_sec <= SEC_MAX)
    `MSCT_ASSERT_NEXT(a_result_follows, process, o_valid)

endmodule

`default_nettype wire
